>>> rtl/core/htd_pkg.sv
// Shared types and constants for the Huffman tree decoder.
// Field widths, command and status codes, and the result struct.
// No dependencies.
`timescale 1ns / 1ps

package htd_pkg;

  // Item field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CODE_W     = 16;
  localparam int unsigned CODE_IDX_W = 4;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned ST_W       = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BIT   = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_SYMBOL     = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_PATH   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL       = 2'd2;
  localparam logic [ST_W-1:0] ST_INCOMPLETE = 2'd3;

  // One result from the sequencer to the output register
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
    logic [ST_W-1:0]  status;
  } htd_res_t;

endpackage

>>> rtl/core/htd_if.sv
// Valid/ready channel interfaces for the Huffman tree decoder.
// Depends on htd_pkg for field widths.
`timescale 1ns / 1ps

interface htd_in_if;
  logic                       valid;
  logic                       ready;
  logic [htd_pkg::CMD_W-1:0]  cmd;
  logic [htd_pkg::CODE_W-1:0] code_bits;
  logic [htd_pkg::LEN_W-1:0]  code_length;
  logic [htd_pkg::SYM_W-1:0]  symbol;
  logic                       bit_req;
  logic                       last_bit;

  modport source(output valid, cmd, code_bits, code_length, symbol, bit_req, last_bit,
                 input ready);
  modport sink(input valid, cmd, code_bits, code_length, symbol, bit_req, last_bit,
               output ready);
endinterface

interface htd_out_if;
  logic                      valid;
  logic                      ready;
  logic [htd_pkg::SYM_W-1:0] out_symbol;
  logic [htd_pkg::ST_W-1:0]  status;

  modport source(output valid, out_symbol, status, input ready);
  modport sink(input valid, out_symbol, status, output ready);
endinterface

>>> rtl/core/htd_node_mem.sv
// Node store: one write port, one registered read port.
// Holds every tree node but the root. No dependencies.
`timescale 1ns / 1ps

module htd_node_mem #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9,
  parameter int unsigned DW    = 26
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/htd_ctrl.sv
// Sequencer of the Huffman tree decoder: tree walk for loads and decode steps.
// Keeps the root, node count and current node; drives the node store.
// Depends on htd_pkg and htd_in_if.
`timescale 1ns / 1ps

module htd_ctrl #(
  parameter int unsigned MAX_CODE_LEN   = 16,
  parameter int unsigned NODE_COUNT_MAX = 512,
  parameter int unsigned IW             = $clog2(NODE_COUNT_MAX),
  parameter int unsigned EW             = 2 * IW + htd_pkg::SYM_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  htd_in_if.sink            in_i,
  input  logic              out_free_i,
  output htd_pkg::htd_res_t res_o,
  output logic              mem_we_o,
  output logic [IW-1:0]     mem_waddr_o,
  output logic [EW-1:0]     mem_wdata_o,
  output logic [IW-1:0]     mem_raddr_o,
  input  logic [EW-1:0]     mem_rdata_i
);
  import htd_pkg::*;

  localparam int unsigned CW = $clog2(NODE_COUNT_MAX + 1);
  localparam int unsigned KW = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned LW = (KW > LEN_W) ? KW : LEN_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DCHK = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [EW-1:0]    root_q, root_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IW-1:0]    cur_idx_q, cur_idx_d;
  logic [2*IW-1:0]  cur_kids_q, cur_kids_d;
  logic [IW-1:0]    node_q, node_d;
  logic [EW-1:0]    ent_q, ent_d;
  logic             dirty_q, dirty_d;
  logic [LW-1:0]    k_q, k_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [SYM_W-1:0] sym_q, sym_d;
  logic             last_q, last_d;
  logic [IW-1:0]    child_q, child_d;
  logic [SYM_W-1:0] pend_sym_q, pend_sym_d;
  logic [ST_W-1:0]  pend_st_q, pend_st_d;

  logic             res_req;
  logic [SYM_W-1:0] res_sym;
  logic [ST_W-1:0]  res_st;
  logic             wr_req;
  logic [EW-1:0]    wr_ent;

  logic [LW-1:0]    len_ext, len_eff, pos;
  logic             walk_bit;
  logic [IW-1:0]    ent_left, ent_right, slot, fresh;
  logic [2*IW-1:0]  here_kids;
  logic [IW-1:0]    dec_child, rd_left, rd_right;
  logic             full;

  // Clamp the code length
  assign len_ext = LW'(in_i.code_length);
  assign len_eff = (len_ext > LW'(MAX_CODE_LEN)) ? LW'(MAX_CODE_LEN) : len_ext;

  // Code bit for this walk step, MSB first; positions past the field read 0
  assign pos      = k_q - LW'(1);
  assign walk_bit = (pos < LW'(CODE_W)) ? code_q[pos[CODE_IDX_W-1:0]] : 1'b0;

  // Split the node being walked
  assign ent_left  = ent_q[EW-1 -: IW];
  assign ent_right = ent_q[EW-1-IW -: IW];
  assign slot      = walk_bit ? ent_right : ent_left;
  assign fresh     = count_q[IW-1:0];
  assign full      = (count_q >= CW'(NODE_COUNT_MAX));

  // Children of the current decode node
  assign here_kids = (cur_idx_q == '0) ? root_q[EW-1 -: 2*IW] : cur_kids_q;
  assign dec_child = in_i.bit_req ? here_kids[IW-1:0] : here_kids[2*IW-1 -: IW];
  assign rd_left   = mem_rdata_i[EW-1 -: IW];
  assign rd_right  = mem_rdata_i[EW-1-IW -: IW];

  assign in_i.ready = (state_q == S_IDLE);

  // Next state and node store access
  always_comb begin
    state_d    = state_q;
    root_d     = root_q;
    count_d    = count_q;
    cur_idx_d  = cur_idx_q;
    cur_kids_d = cur_kids_q;
    node_d     = node_q;
    ent_d      = ent_q;
    dirty_d    = dirty_q;
    k_d        = k_q;
    code_d     = code_q;
    sym_d      = sym_q;
    last_d     = last_q;
    child_d    = child_q;
    pend_sym_d = pend_sym_q;
    pend_st_d  = pend_st_q;
    res_req    = 1'b0;
    res_sym    = '0;
    res_st     = ST_SYMBOL;
    wr_req     = 1'b0;
    wr_ent     = ent_q;
    mem_raddr_o = '0;
    res_o      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          unique case (in_i.cmd)
            CMD_CLEAR: begin
              root_d    = '0;
              count_d   = CW'(1);
              cur_idx_d = '0;
            end
            CMD_LOAD: begin
              cur_idx_d = '0;
              node_d    = '0;
              ent_d     = root_q;
              dirty_d   = 1'b0;
              k_d       = len_eff;
              code_d    = in_i.code_bits;
              sym_d     = in_i.symbol;
              if (len_eff != '0) begin
                state_d = S_WALK;
              end
            end
            CMD_BIT: begin
              if (dec_child == '0) begin
                res_req   = 1'b1;
                res_st    = ST_BAD_PATH;
                cur_idx_d = '0;
              end else begin
                mem_raddr_o = dec_child;
                child_d     = dec_child;
                last_d      = in_i.last_bit;
                state_d     = S_DCHK;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        k_d = k_q - LW'(1);
        if (slot != '0) begin
          // Step to an existing child; flush the node we leave
          mem_raddr_o = slot;
          wr_req      = dirty_q;
          node_d      = slot;
          state_d     = S_WAIT;
        end else if (full) begin
          // Store exhausted: keep what was built, report
          wr_req  = dirty_q;
          res_req = 1'b1;
          res_st  = ST_FULL;
        end else begin
          // Allocate a child and link it into the node we leave
          wr_req  = 1'b1;
          wr_ent  = walk_bit ? {ent_left, fresh, ent_q[SYM_W-1:0]}
                             : {fresh, ent_right, ent_q[SYM_W-1:0]};
          node_d  = fresh;
          ent_d   = '0;
          dirty_d = 1'b1;
          count_d = count_q + CW'(1);
          state_d = (k_q == LW'(1)) ? S_FIN : S_WALK;
        end
      end
      S_WAIT: begin
        ent_d   = mem_rdata_i;
        dirty_d = 1'b0;
        state_d = (k_q == '0) ? S_FIN : S_WALK;
      end
      S_FIN: begin
        // Mark the end node with the symbol
        wr_req  = 1'b1;
        wr_ent  = {ent_q[EW-1 -: 2*IW], sym_q};
        state_d = S_IDLE;
      end
      S_DCHK: begin
        if (rd_left == '0 && rd_right == '0) begin
          res_req   = 1'b1;
          res_sym   = mem_rdata_i[SYM_W-1:0];
          res_st    = ST_SYMBOL;
          cur_idx_d = '0;
        end else if (last_q) begin
          res_req   = 1'b1;
          res_st    = ST_INCOMPLETE;
          cur_idx_d = '0;
        end else begin
          cur_idx_d  = child_q;
          cur_kids_d = mem_rdata_i[EW-1 -: 2*IW];
          state_d    = S_IDLE;
        end
      end
      S_RESP: begin
        res_req = 1'b1;
        res_sym = pend_sym_q;
        res_st  = pend_st_q;
      end
      default: state_d = S_IDLE;
    endcase

    // Hand the result over, or hold it until the output register frees
    if (res_req) begin
      if (out_free_i) begin
        res_o.valid  = 1'b1;
        res_o.sym    = res_sym;
        res_o.status = res_st;
        state_d      = S_IDLE;
      end else begin
        pend_sym_d = res_sym;
        pend_st_d  = res_st;
        state_d    = S_RESP;
      end
    end

    // Root lives in flops, all other nodes in the store
    if (wr_req && node_q == '0) begin
      root_d = wr_ent;
    end
  end

  assign mem_we_o    = wr_req && (node_q != '0);
  assign mem_waddr_o = node_q;
  assign mem_wdata_o = wr_ent;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      root_q    <= '0;
      count_q   <= CW'(1);
      cur_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      root_q    <= root_d;
      count_q   <= count_d;
      cur_idx_q <= cur_idx_d;
    end
  end

  // Walk and result payload
  always_ff @(posedge clk_i) begin
    cur_kids_q <= cur_kids_d;
    node_q     <= node_d;
    ent_q      <= ent_d;
    dirty_q    <= dirty_d;
    k_q        <= k_d;
    code_q     <= code_d;
    sym_q      <= sym_d;
    last_q     <= last_d;
    child_q    <= child_d;
    pend_sym_q <= pend_sym_d;
    pend_st_q  <= pend_st_d;
  end

endmodule

>>> rtl/core/huffman_tree_decoder.sv
// Huffman tree decoder top level: sequencer, node store and output register.
// Depends on htd_pkg, htd_if, htd_node_mem and htd_ctrl.
//
//   Port    Dir  Handshake     Transfer
//   in_i    in   valid/ready   cmd, code_bits, code_length, symbol, bit_req, last_bit
//   out_o   out  valid/ready   out_symbol, status
//
// Decode bit: the child node is fetched by the registered read of the store, then checked;
// with no child on that side the bad-path result is given without a store read.
// Clear is taken in idle. Load: S_WALK and S_WAIT per existing node passed, S_WALK per new
// node, then S_FIN; a zero length does not walk and a full store ends the walk early.
// Reset puts the root in flops and the count at one; the store needs no clearing pass.
// One item at a time; one result may wait at out_o, a second holds the input until it drains.
`timescale 1ns / 1ps

module huffman_tree_decoder #(
  parameter int unsigned MAX_CODE_LEN   = 16,
  parameter int unsigned NODE_COUNT_MAX = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  htd_in_if.sink     in_i,
  htd_out_if.source  out_o
);
  import htd_pkg::*;

  localparam int unsigned IW = $clog2(NODE_COUNT_MAX);
  localparam int unsigned EW = 2 * IW + SYM_W;

  htd_res_t         res;
  logic             out_free;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  logic [EW-1:0]    mem_wdata, mem_rdata;
  logic             ov_q;
  logic [SYM_W-1:0] osym_q;
  logic [ST_W-1:0]  ost_q;

  htd_ctrl #(
    .MAX_CODE_LEN  (MAX_CODE_LEN),
    .NODE_COUNT_MAX(NODE_COUNT_MAX),
    .IW            (IW),
    .EW            (EW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_free_i (out_free),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  htd_node_mem #(
    .DEPTH(NODE_COUNT_MAX),
    .AW   (IW),
    .DW   (EW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Output slot is free when empty or draining this cycle
  assign out_free = !ov_q || out_o.ready;

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (res.valid) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  // Output payload: load on a new result, hold otherwise
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      osym_q <= res.sym;
      ost_q  <= res.status;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.out_symbol = osym_q;
  assign out_o.status     = ost_q;

endmodule

>>> rtl/core/htd_checker.sv
// Port-level checks for the Huffman tree decoder, bound to the top level.
// Depends on htd_pkg and huffman_tree_decoder.
`timescale 1ns / 1ps

module htd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [htd_pkg::CMD_W-1:0]   in_cmd_i,
  input logic [htd_pkg::LEN_W-1:0]   in_len_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [htd_pkg::SYM_W-1:0]   out_symbol_i,
  input logic [htd_pkg::ST_W-1:0]    out_status_i
);
  import htd_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // A load that walks the tree closes the input in the cycle after it is taken
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_cmd_i == CMD_LOAD && in_len_i != '0 |=> !in_ready_i)
    else $error("input ready right after a walking load");

  // A clear never produces a result
  a_clear_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_cmd_i == CMD_CLEAR && !out_valid_i |=> !out_valid_i)
    else $error("result after a clear");

  // Error results carry a zero symbol
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_SYMBOL |-> out_symbol_i == '0)
    else $error("nonzero symbol on an error result");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_symbol_i) && $stable(out_status_i))
    else $error("stalled result changed");

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.cmd),
  .in_len_i    (in_i.code_length),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_symbol_i(out_o.out_symbol),
  .out_status_i(out_o.status)
);

>>> dv/huffman_tree_decoder_tb.sv
// Self-checking testbench for the Huffman tree decoder.
// Drives clear, load and bit commands on the input channel and checks each result against
// a software copy of the code tree or a typed expectation. Depends on htd_pkg, htd_if and the RTL.
`timescale 1ns / 1ps

module huffman_tree_decoder_tb;
  import htd_pkg::*;

  localparam int unsigned MAXLEN      = 16;
  localparam int unsigned NODES       = 512;
  localparam int          IDLE_LIMIT  = 4000;
  localparam int          PHASE_ITEMS = 120;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic [SYM_W-1:0]  symbol;
    logic              bit_req;
    logic              last_bit;
  } item_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [ST_W-1:0]  status;
  } res_t;

  // How a directed row is checked: by the tree copy, typed as silent, or typed result
  typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_RESULT} chk_e;

  typedef struct {
    item_t            it;
    chk_e             chk;
    logic [SYM_W-1:0] tsym;
    logic [ST_W-1:0]  tst;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  htd_in_if  in_if ();
  htd_out_if out_if ();

  huffman_tree_decoder #(
    .MAX_CODE_LEN  (MAXLEN),
    .NODE_COUNT_MAX(NODES)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Software copy of the code tree
  logic [8:0]       kid_l [NODES];
  logic [8:0]       kid_r [NODES];
  logic [SYM_W-1:0] nsym  [NODES];
  int unsigned      ncount;
  logic [8:0]       cur;

  res_t predicted_out_q[$];
  int   errors = 0;
  int   sent;
  int   idle_cycles = 0;
  int   gap_pct;
  int   stall_pct;

  // Typed expectation travelling with the item on the input channel
  chk_e             drv_chk;
  logic [SYM_W-1:0] drv_sym;
  logic [ST_W-1:0]  drv_st;

  // Code set under construction for one well-formed stream
  logic [15:0] cs_bits[$];
  int          cs_len[$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Apply one item to the tree copy and say which result it causes
  function automatic void tree_step(input item_t it, output bit has, output res_t r);
    int          n;
    int          k;
    logic [8:0]  node;
    logic [8:0]  child;
    logic        b;
    bit          full;
    has = 1'b0;
    r = '0;
    if (cur >= ncount) cur = '0;
    case (it.cmd)
      CMD_CLEAR: begin
        kid_l[0] = '0;
        kid_r[0] = '0;
        nsym[0] = '0;
        ncount = 1;
        cur = '0;
      end
      CMD_LOAD: begin
        cur = '0;
        if (it.code_length != 0) begin
          n = (it.code_length > MAXLEN) ? MAXLEN : it.code_length;
          node = '0;
          full = 1'b0;
          for (k = n; k > 0 && !full; k--) begin
            b = it.code_bits[k-1];
            child = b ? kid_r[node] : kid_l[node];
            if (child == 0) begin
              if (ncount >= NODES) begin
                full = 1'b1;
              end else begin
                child = ncount[8:0];
                kid_l[child] = '0;
                kid_r[child] = '0;
                nsym[child] = '0;
                ncount++;
                if (b) kid_r[node] = child;
                else kid_l[node] = child;
              end
            end
            if (!full) node = child;
          end
          if (full) begin
            has = 1'b1;
            r.status = ST_FULL;
          end else begin
            nsym[node] = it.symbol;
          end
        end
      end
      CMD_BIT: begin
        child = it.bit_req ? kid_r[cur] : kid_l[cur];
        if (child == 0 || child >= ncount) begin
          cur = '0;
          has = 1'b1;
          r.status = ST_BAD_PATH;
        end else if (kid_l[child] == 0 && kid_r[child] == 0) begin
          cur = '0;
          has = 1'b1;
          r.sym = nsym[child];
          r.status = ST_SYMBOL;
        end else if (it.last_bit) begin
          cur = '0;
          has = 1'b1;
          r.status = ST_INCOMPLETE;
        end else begin
          cur = child;
        end
      end
      default: ;
    endcase
  endfunction

  // Check results leaving the block, then predict for the item coming in
  always @(posedge clk_i) begin : monitor
    item_t it;
    res_t  r;
    res_t  want;
    bit    has;
    if (!rst_ni) begin
      // Hold the tree copy at its reset state: bare root, current node at the root
      for (int i = 0; i < NODES; i++) begin
        kid_l[i] = '0;
        kid_r[i] = '0;
        nsym[i]  = '0;
      end
      ncount = 1;
      cur    = '0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (predicted_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result sym %0h status %0d",
                                    out_if.out_symbol, out_if.status));
        end else begin
          want = predicted_out_q.pop_front();
          if (out_if.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_if.status, want.status));
          if (out_if.out_symbol !== want.sym)
            report_mismatch($sformatf("out_symbol got %0h want %0h",
                                      out_if.out_symbol, want.sym));
        end
      end
      if (in_if.valid && in_if.ready) begin
        it = '{in_if.cmd, in_if.code_bits, in_if.code_length, in_if.symbol,
               in_if.bit_req, in_if.last_bit};
        tree_step(it, has, r);
        if (drv_chk == CHK_RESULT) begin
          has = 1'b1;
          r.sym = drv_sym;
          r.status = drv_st;
        end else if (drv_chk == CHK_QUIET) begin
          has = 1'b0;
        end
        if (has) predicted_out_q = {predicted_out_q, r};
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when nothing has moved for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic item_t random_item();
    item_t it;
    it.cmd         = CMD_W'($urandom_range(3));
    it.code_bits   = CODE_W'($urandom);
    it.code_length = LEN_W'($urandom);
    it.symbol      = SYM_W'($urandom);
    it.bit_req     = 1'($urandom_range(1));
    it.last_bit    = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic row_t row(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] cb,
                               input logic [LEN_W-1:0] len, input logic [SYM_W-1:0] sym,
                               input logic b, input logic last, input chk_e chk,
                               input logic [SYM_W-1:0] tsym, input logic [ST_W-1:0] tst);
    row_t r;
    r.it   = '{cmd, cb, len, sym, b, last};
    r.chk  = chk;
    r.tsym = tsym;
    r.tst  = tst;
    return r;
  endfunction

  // Offer one item, with random sender gaps, and hold it until the transfer
  task automatic send_item(input item_t it, input chk_e chk = CHK_MODEL,
                           input logic [SYM_W-1:0] tsym = '0,
                           input logic [ST_W-1:0] tst = '0);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= it.cmd;
    in_if.code_bits   <= it.code_bits;
    in_if.code_length <= it.code_length;
    in_if.symbol      <= it.symbol;
    in_if.bit_req     <= it.bit_req;
    in_if.last_bit    <= it.last_bit;
    drv_chk           <= chk;
    drv_sym           <= tsym;
    drv_st            <= tst;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (it.cmd != CMD_UNUSED) sent++;
  endtask

  // Hold the sender until every pending result is out, then let the block settle
  task automatic drain(input int settle);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (predicted_out_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Grow a complete prefix code by splitting leaves; chain mode builds one deep spine
  function automatic void build_code_set(input int leaves, input bit chain);
    int          pick;
    logic [15:0] b;
    int          l;
    cs_bits.delete();
    cs_len.delete();
    cs_bits = {cs_bits, 16'h0};
    cs_len = {cs_len, 0};
    while (cs_bits.size() < leaves) begin
      pick = chain ? cs_bits.size() - 1 : $urandom_range(cs_bits.size() - 1);
      b = cs_bits[pick];
      l = cs_len[pick];
      cs_bits[pick] = b << 1;
      cs_len[pick] = l + 1;
      cs_bits = {cs_bits, (b << 1) | 16'h1};
      cs_len = {cs_len, l + 1};
    end
  endfunction

  task automatic send_load(input logic [15:0] code, input int len);
    item_t       it;
    logic [31:0] mask;
    it = random_item();
    it.cmd = CMD_LOAD;
    mask = (32'h1 << len) - 1;
    it.code_bits = (it.code_bits & ~mask[15:0]) | (code & mask[15:0]);
    it.code_length = LEN_W'(len);
    // Over-long length fields are clamped by the block
    if (len == MAXLEN && $urandom_range(1)) it.code_length = LEN_W'($urandom_range(17, 31));
    send_item(it);
  endtask

  // Load a code set, then decode a stream of its symbols, now and then broken
  task automatic run_stream();
    item_t it;
    bit    chain;
    int    leaves;
    int    skip;
    int    nsyms;
    int    pick;
    int    cut;
    int    len;
    int    s;
    int    k;
    if ($urandom_range(9) < 8) begin
      it = random_item();
      it.cmd = CMD_CLEAR;
      send_item(it);
    end
    chain = ($urandom_range(7) == 0);
    leaves = chain ? $urandom_range(8, 17) : $urandom_range(2, 10);
    build_code_set(leaves, chain);
    skip = ($urandom_range(9) == 0) ? $urandom_range(leaves - 1) : -1;
    foreach (cs_bits[j]) begin
      if (j != skip) send_load(cs_bits[j], cs_len[j]);
    end
    nsyms = $urandom_range(1, 8);
    for (s = 0; s < nsyms; s++) begin
      pick = $urandom_range(leaves - 1);
      len = cs_len[pick];
      cut = len;
      if (s == nsyms - 1 && len > 1 && $urandom_range(9) == 0) cut = $urandom_range(1, len - 1);
      for (k = 0; k < cut; k++) begin
        it = random_item();
        it.cmd = CMD_BIT;
        it.bit_req = cs_bits[pick][len-1-k];
        if ($urandom_range(19) == 0) it.bit_req = ~it.bit_req;
        it.last_bit = (s == nsyms - 1 && k == cut - 1);
        send_item(it);
      end
    end
  endtask

  // Random commands of every kind, reserved code included
  task automatic run_noise();
    item_t it;
    int    n;
    int    w;
    n = $urandom_range(1, 8);
    repeat (n) begin
      it = random_item();
      w = $urandom_range(99);
      if (w < 5) it.cmd = CMD_CLEAR;
      else if (w < 35) it.cmd = CMD_LOAD;
      else if (w < 90) it.cmd = CMD_BIT;
      else it.cmd = CMD_UNUSED;
      send_item(it);
    end
  endtask

  // Fill the node store with long random codes until loads report it full
  task automatic run_fill();
    item_t it;
    it = random_item();
    it.cmd = CMD_CLEAR;
    send_item(it);
    repeat (44) send_load(CODE_W'($urandom), MAXLEN);
    repeat (12) begin
      it = random_item();
      it.cmd = CMD_BIT;
      send_item(it);
    end
  endtask

  initial begin : stimulus
    row_t dir_tab[$];
    int   phase_end;
    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_CLEAR;
    in_if.code_bits   = '0;
    in_if.code_length = '0;
    in_if.symbol      = '0;
    in_if.bit_req     = 1'b0;
    in_if.last_bit    = 1'b0;
    drv_chk           = CHK_MODEL;
    drv_sym           = '0;
    drv_st            = '0;
    sent              = 0;
    gap_pct           = 0;
    stall_pct         = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bare root, small tree, leaf turned inner, clamp, reserved code, clear
    dir_tab = {dir_tab, row(CMD_BIT, 16'h0000, 5'd0, 8'h00, 1'b0, 1'b0,
                            CHK_RESULT, 8'h00, ST_BAD_PATH)};
    dir_tab = {dir_tab, row(CMD_BIT, 16'hFFFF, 5'd31, 8'hFF, 1'b1, 1'b1,
                            CHK_RESULT, 8'h00, ST_BAD_PATH)};
    dir_tab = {dir_tab, row(CMD_LOAD, 16'hFFFF, 5'd0, 8'h11, 1'b0, 1'b0,
                            CHK_QUIET, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_LOAD, 16'h0000, 5'd1, 8'h41, 1'b0, 1'b0,
                            CHK_QUIET, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_LOAD, 16'h0002, 5'd2, 8'h42, 1'b1, 1'b1,
                            CHK_QUIET, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_LOAD, 16'hFFFF, 5'd2, 8'h43, 1'b0, 1'b0,
                            CHK_QUIET, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_BIT, 16'h0000, 5'd0, 8'h00, 1'b0, 1'b0,
                            CHK_MODEL, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_BIT, 16'h0000, 5'd0, 8'h00, 1'b1, 1'b0,
                            CHK_MODEL, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_BIT, 16'h0000, 5'd0, 8'h00, 1'b1, 1'b0,
                            CHK_MODEL, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_BIT, 16'h0000, 5'd0, 8'h00, 1'b1, 1'b1,
                            CHK_RESULT, 8'h00, ST_INCOMPLETE)};
    dir_tab = {dir_tab, row(CMD_BIT, 16'h0000, 5'd0, 8'h00, 1'b1, 1'b0,
                            CHK_MODEL, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_BIT, 16'h0000, 5'd0, 8'h00, 1'b0, 1'b1,
                            CHK_MODEL, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_LOAD, 16'hFFFF, 5'd16, 8'hFF, 1'b0, 1'b0,
                            CHK_QUIET, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_LOAD, 16'h0000, 5'd31, 8'h00, 1'b0, 1'b0,
                            CHK_MODEL, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_LOAD, 16'h8001, 5'd17, 8'h80, 1'b1, 1'b0,
                            CHK_MODEL, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_BIT, 16'h0000, 5'd0, 8'h00, 1'b0, 1'b0,
                            CHK_MODEL, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_BIT, 16'h0000, 5'd0, 8'h00, 1'b1, 1'b0,
                            CHK_RESULT, 8'h00, ST_BAD_PATH)};
    dir_tab = {dir_tab, row(CMD_UNUSED, 16'hFFFF, 5'd31, 8'hFF, 1'b1, 1'b1,
                            CHK_QUIET, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_LOAD, 16'h0001, 5'd1, 8'h55, 1'b0, 1'b0,
                            CHK_QUIET, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_BIT, 16'h0000, 5'd0, 8'h00, 1'b1, 1'b1,
                            CHK_RESULT, 8'h00, ST_INCOMPLETE)};
    dir_tab = {dir_tab, row(CMD_BIT, 16'h0000, 5'd0, 8'h00, 1'b0, 1'b0,
                            CHK_MODEL, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_CLEAR, 16'hFFFF, 5'd31, 8'hFF, 1'b1, 1'b1,
                            CHK_QUIET, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_BIT, 16'h0000, 5'd0, 8'h00, 1'b0, 1'b0,
                            CHK_RESULT, 8'h00, ST_BAD_PATH)};
    dir_tab = {dir_tab, row(CMD_LOAD, 16'h0001, 5'd1, 8'hFF, 1'b0, 1'b0,
                            CHK_QUIET, 8'h00, ST_SYMBOL)};
    dir_tab = {dir_tab, row(CMD_BIT, 16'h0000, 5'd0, 8'h00, 1'b1, 1'b1,
                            CHK_RESULT, 8'hFF, ST_SYMBOL)};
    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].chk, dir_tab[i].tsym, dir_tab[i].tst);
    drain(40);

    // Random: no idling, sender gaps, receiver stalls, then both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 60; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 60; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase
      phase_end = sent + PHASE_ITEMS;
      if (phase % 2 == 0) run_fill();
      while (sent < phase_end) begin
        if ($urandom_range(9) < 7) run_stream();
        else run_noise();
      end
      drain(40);
    end

    drain(64);
    if (predicted_out_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_out_q.size()));
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
